// ===== rtl/mss_pkg.sv =====
// Shared constants, codes and types of the multi-stack slot store.
package mss_pkg;

  localparam int TOTAL_SLOTS = 256;
  localparam int MAX_STACKS  = 8;
  localparam int DATA_WIDTH  = 32;

  localparam int SLOT_AW    = $clog2(TOTAL_SLOTS);
  localparam int SEL_W      = $clog2(MAX_STACKS);
  localparam int FILL_W     = 9;
  localparam int NSTK_W     = 4;
  localparam int PSIZE_W    = 9;
  localparam int BASE_W     = SEL_W + PSIZE_W;
  localparam int SUM_W      = BASE_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [NSTK_W-1:0]  NSTK_RESET  = NSTK_W'(8);
  localparam logic [PSIZE_W-1:0] PSIZE_RESET = PSIZE_W'(32);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STACKS = 1'b0,
    CFG_PART_SIZE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_out;
  } mss_cmd_t;

endpackage

// ===== rtl/mss_intf.sv =====
// Channel interfaces: request, result and configuration write.
interface mss_req_if;
  import mss_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SEL_W-1:0]    stack_sel;
  logic signed [31:0]  push_value;

  modport source (output valid, req_type, stack_sel, push_value, input ready);
  modport sink   (input valid, req_type, stack_sel, push_value, output ready);
endinterface

interface mss_rsp_if;
  import mss_pkg::*;
  logic                valid;
  logic                ready;
  status_e             status;
  logic signed [31:0]  pop_value;
  logic [7:0]          slot_index;

  modport source (output valid, status, pop_value, slot_index, input ready);
  modport sink   (input valid, status, pop_value, slot_index, output ready);
endinterface

interface mss_cfg_if;
  import mss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mss_ctrl.sv =====
// Sequencing controller: request intake, execute step and result register control.
module mss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output mss_pkg::mss_cmd_t cmd_o
);
  import mss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free       = !out_valid_q || rsp_ready_i;
  assign req_ready_o    = (state_q == S_IDLE);
  assign rsp_valid_o    = out_valid_q;
  assign cmd_o.load_req = req_valid_i && req_ready_o;
  assign cmd_o.exec     = (state_q == S_EVAL);
  assign cmd_o.load_out = (state_q == S_RESP) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load_req) state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A request beat is always followed by exactly one execute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> cmd_o.exec)
    else $error("execute step did not follow request beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  // Loading the result register must present a result beat next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> rsp_valid_o)
    else $error("loaded result not presented");

endmodule

// ===== rtl/mss_dp.sv =====
// Datapath: configuration, fill counts, slot memory and result register.
module mss_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mss_pkg::mss_cmd_t               cmd_i,
  input  logic                            req_type_i,
  input  logic [mss_pkg::SEL_W-1:0]       stack_sel_i,
  input  logic signed [31:0]              push_value_i,
  input  logic                            cfg_we_i,
  input  logic [mss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output mss_pkg::status_e                status_o,
  output logic signed [31:0]              pop_value_o,
  output logic [7:0]                      slot_index_o
);
  import mss_pkg::*;

  logic [NSTK_W-1:0]     nstk_q;
  logic [PSIZE_W-1:0]    psize_q;
  logic [FILL_W-1:0]     fill_q [MAX_STACKS];

  logic                  req_type_q;
  logic [SEL_W-1:0]      sel_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [DATA_WIDTH-1:0] slot_mem [TOTAL_SLOTS];
  logic [DATA_WIDTH-1:0] rdata_q;
  status_e               status_q;
  logic [SLOT_AW-1:0]    addr_q;
  logic                  pop_ok_q;

  status_e               out_status_q;
  logic [DATA_WIDTH-1:0] out_pop_q;
  logic [7:0]            out_slot_q;

  logic [FILL_W-1:0]     fill_cur;
  logic [FILL_W-1:0]     pos;
  logic [BASE_W-1:0]     base;
  logic [SUM_W-1:0]      addr_sum;
  logic [SLOT_AW-1:0]    slot;
  logic                  is_pop;
  status_e               status_d;
  logic                  op_ok;

  assign is_pop   = (req_type_q == REQ_POP);
  assign fill_cur = fill_q[sel_q];
  assign pos      = is_pop ? fill_cur - FILL_W'(1) : fill_cur;
  assign base     = BASE_W'(sel_q) * BASE_W'(psize_q);
  assign addr_sum = SUM_W'(base) + SUM_W'(pos);
  // The slot address wraps modulo the memory depth.
  assign slot     = addr_sum[SLOT_AW-1:0];

  always_comb begin
    if ({1'b0, sel_q} >= nstk_q) begin
      status_d = ST_BAD;
    end else if (!is_pop) begin
      status_d = (fill_cur >= psize_q) ? ST_FULL : ST_OK;
    end else begin
      status_d = (fill_cur == '0) ? ST_EMPTY : ST_OK;
    end
  end

  assign op_ok = (status_d == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nstk_q  <= NSTK_RESET;
      psize_q <= PSIZE_RESET;
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_STACKS) begin
          nstk_q <= cfg_data_i[NSTK_W-1:0];
        end else if (cfg_idx_i == CFG_PART_SIZE) begin
          psize_q <= cfg_data_i[PSIZE_W-1:0];
        end
      end
      if (cmd_i.exec && op_ok) begin
        fill_q[sel_q] <= is_pop ? fill_cur - FILL_W'(1) : fill_cur + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      sel_q      <= stack_sel_i;
      val_q      <= push_value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      addr_q   <= op_ok ? slot : '0;
      pop_ok_q <= op_ok && is_pop;
      if (op_ok && !is_pop) begin
        slot_mem[slot] <= val_q;
      end
      rdata_q <= slot_mem[slot];
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_pop_q    <= pop_ok_q ? rdata_q : '0;
      out_slot_q   <= 8'(addr_q);
    end
  end

  assign status_o     = out_status_q;
  assign pop_value_o  = out_pop_q;
  assign slot_index_o = out_slot_q;

  // A successful push grows the addressed stack by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && op_ok && !is_pop |=>
      fill_q[sel_q] == $past(fill_q[sel_q]) + FILL_W'(1))
    else $error("push did not advance fill count");

  // A rejected request leaves the addressed stack untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && !op_ok |=> fill_q[sel_q] == $past(fill_q[sel_q]))
    else $error("rejected request changed fill count");

endmodule

// ===== rtl/multi_stack_single_store.sv =====
// Top level of the multi-stack slot store.
//
// Several LIFO stacks share one slot memory, each owning an equal fixed
// partition. A beat on req_i carries a push or a pop, a stack number and a
// push value; every request beat yields exactly one beat on rsp_o with a
// status (ok, full, empty, bad stack), the popped value and the slot used.
// cfg_i writes the stack count (index 0) and the partition size (index 1);
// it is always ready and is meant to be written only while the block is idle.
// A request is captured at intake, then executed, and its result beat is
// offered once the result register is loaded. A new request is taken only
// after the controller walks the last one through intake, one access of the
// single-port slot memory with its fill-count update, and the result load.
// A waiting result sits in the result register while the next request is
// taken; if rsp_o stalls, the following result holds in the datapath and no
// further request is taken until the register frees.
// Reset clears all fill counts and loads stack count 8 and partition size 32.
// Slot memory contents are not cleared; no clearing pass is needed.
module multi_stack_single_store (
  input  logic clk_i,
  input  logic rst_ni,
  mss_req_if.sink   req_i,
  mss_rsp_if.source rsp_o,
  mss_cfg_if.sink   cfg_i
);
  import mss_pkg::*;

  mss_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  mss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  mss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_i.req_type),
    .stack_sel_i  (req_i.stack_sel),
    .push_value_i (req_i.push_value),
    .cfg_we_i     (cfg_i.valid && cfg_i.ready),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .status_o     (rsp_o.status),
    .pop_value_o  (rsp_o.pop_value),
    .slot_index_o (rsp_o.slot_index)
  );

endmodule
